[design/ugcl_pkg.sv]
// Shared types, codes and defaults of the uniform grid cell list.
package ugcl_pkg;

    localparam int UGCL_MAX_COLS      = 64;
    localparam int UGCL_MAX_ROWS      = 64;
    localparam int UGCL_PART_DEPTH    = 4096;
    localparam int UGCL_CELL_SHIFT    = 4;
    localparam int UGCL_LIST_CAP      = 64;

    localparam logic [6:0]  RST_GRID_COLS      = 7'd64;
    localparam logic [6:0]  RST_GRID_ROWS      = 7'd64;
    localparam logic [12:0] RST_PARTICLE_LIMIT = 13'd4096;

    localparam logic [1:0] REG_GRID_COLS      = 2'd0;
    localparam logic [1:0] REG_GRID_ROWS      = 2'd1;
    localparam logic [1:0] REG_PARTICLE_LIMIT = 2'd2;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_MOVE   = 2'd2;
    localparam logic [1:0] MODE_LIST   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_UNBINNED = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [11:0]        particle;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [11:0]        cell_select;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] cell_index;
        logic [12:0] cell_count;
        logic        cell_active;
        logic        cell_dirty;
        logic [11:0] member;
        logic        last;
    } t_result;

endpackage

[design/uniform_grid_cell_list.sv]
// Uniform grid cell list: top level with sequencer, cell memory and particle memory.
// After reset the block clears its memories with busy high. Once an item is accepted,
// busy stays high while it runs: a remove of an unbinned particle ends after reading its
// record; an insert or move of an unbinned particle and a move within its cell then
// update the cell; a remove and an insert or move that rebins a binned particle first
// walk the old cell's list up to the particle, since the single-port particle memory is
// walked one link a cycle. An ignored index or an out-of-range cell gives its result in
// the cycle after acceptance and busy stays low. List mode reads the cell, then gives up to
// LIST_CAP members one after another, one read of the particle memory per member. The final
// result of an item is on the ports in the cycle in which busy falls. Results appear for
// one cycle on o_res_valid and cannot be held off; the last result of an item carries last.
module uniform_grid_cell_list #(
    parameter int MAX_COLS      = ugcl_pkg::UGCL_MAX_COLS,
    parameter int MAX_ROWS      = ugcl_pkg::UGCL_MAX_ROWS,
    parameter int PART_DEPTH    = ugcl_pkg::UGCL_PART_DEPTH,
    parameter int CELL_SHIFT    = ugcl_pkg::UGCL_CELL_SHIFT,
    parameter int LIST_CAP      = ugcl_pkg::UGCL_LIST_CAP
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  ugcl_pkg::t_item   i_item,
    output logic              o_res_valid,
    output ugcl_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [12:0]       i_cfg_data
);
    import ugcl_pkg::*;

    localparam int NCELLS = MAX_COLS * MAX_ROWS;
    localparam int CW     = NCELLS > 1 ? $clog2(NCELLS) : 1;
    localparam int PW     = $clog2(PART_DEPTH);
    localparam int PCW    = $clog2(PART_DEPTH + 1);
    localparam int COLW   = $clog2(MAX_COLS + 1);
    localparam int ROWW   = $clog2(MAX_ROWS + 1);
    localparam int LCW    = $clog2(LIST_CAP + 1);
    localparam int CLR_N  = NCELLS > PART_DEPTH ? NCELLS : PART_DEPTH;
    localparam int CLRW   = $clog2(CLR_N);

    typedef struct packed {
        logic [PCW-1:0] pop;
        logic           dirty;
        logic [PW-1:0]  head;
    } t_cell_rec;

    typedef struct packed {
        logic           valid;
        logic [CW-1:0]  home;
        logic [PW-1:0]  next;
    } t_part_rec;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_P0, S_P1, S_UCELL, S_UWALK, S_UFIN, S_LRD,
        S_LINK, S_DIRTY, S_LHEAD, S_LEMIT, S_LSTEP
    } t_state;

    t_state     r_state;
    logic [CLRW-1:0] r_clr;
    logic [6:0]  r_cols, r_rows;
    logic [12:0] r_plimit;
    logic [1:0]  r_mode;
    logic [PW-1:0] r_p, r_prev, r_cur;
    logic [CW-1:0] r_c;
    t_part_rec   r_prec;
    t_cell_rec   r_crec;
    logic [LCW-1:0] r_lcnt, r_ln;
    logic        r_res_valid;
    t_result     r_res;

    t_cell_rec   r_cell_mem [NCELLS];
    t_part_rec   r_part_mem [PART_DEPTH];
    t_cell_rec   r_cell_q;
    t_part_rec   r_part_q;

    logic [CW-1:0] cell_addr;
    logic          cell_we;
    t_cell_rec     cell_wd;
    logic [PW-1:0] part_addr;
    logic          part_we;
    t_part_rec     part_wd;

    logic            accept;
    logic            bin_load;
    logic [CW-1:0]   bin_cell;
    logic [COLW-1:0] eff_cols;
    logic [ROWW-1:0] eff_rows;
    logic [31:0]     lim32;
    logic            ignored;
    logic            same_cell;

    always_comb begin
        eff_cols = (r_cols == '0) ? COLW'(1) :
                   (32'(r_cols) > MAX_COLS) ? COLW'(MAX_COLS) : COLW'(r_cols);
        eff_rows = (r_rows == '0) ? ROWW'(1) :
                   (32'(r_rows) > MAX_ROWS) ? ROWW'(MAX_ROWS) : ROWW'(r_rows);
        lim32 = (32'(r_plimit) < 32'(PART_DEPTH)) ? 32'(r_plimit) : 32'(PART_DEPTH);
        ignored = 32'(i_item.particle) >= lim32;
        accept = i_start && (r_state == S_IDLE);
        same_cell = (r_mode == MODE_MOVE) && r_prec.valid && (r_prec.home == bin_cell);
    end

    ugcl_bin #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .CELL_SHIFT(CELL_SHIFT)
    ) u_bin (
        .i_clk  (i_clk),
        .i_load (bin_load),
        .i_pos_x(i_item.pos_x),
        .i_pos_y(i_item.pos_y),
        .i_cols (eff_cols),
        .i_rows (eff_rows),
        .o_cell (bin_cell)
    );

    // Memory port control per sequencer step.
    always_comb begin
        cell_addr = r_c;
        cell_we   = 1'b0;
        cell_wd   = '0;
        part_addr = r_p;
        part_we   = 1'b0;
        part_wd   = '0;
        bin_load  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                cell_addr = r_clr[CW-1:0];
                part_addr = r_clr[PW-1:0];
                cell_we   = 32'(r_clr) < 32'(NCELLS);
                part_we   = 32'(r_clr) < 32'(PART_DEPTH);
            end
            S_IDLE: begin
                part_addr = PW'(i_item.particle);
                cell_addr = CW'(i_item.cell_select);
                bin_load  = accept;
            end
            S_P1: begin
                cell_addr = (r_prec.valid && !same_cell) ? r_prec.home : bin_cell;
            end
            S_UCELL: begin
                part_addr = r_cell_q.head;
            end
            S_UWALK: begin
                if (r_part_q.next == r_p) begin
                    part_addr = r_prev;
                    part_we   = 1'b1;
                    part_wd   = '{valid: r_part_q.valid, home: r_part_q.home,
                                  next: r_prec.next};
                end else begin
                    part_addr = r_part_q.next;
                end
            end
            S_UFIN: begin
                cell_addr = r_prec.home;
                cell_we   = 1'b1;
                cell_wd   = r_crec;
                part_we   = 1'b1;
            end
            S_LINK: begin
                cell_we = 1'b1;
                cell_wd = '{pop: r_cell_q.pop + 1'b1, dirty: 1'b1, head: r_p};
                part_we = 1'b1;
                part_wd = '{valid: 1'b1, home: r_c, next: r_cell_q.head};
            end
            S_DIRTY: begin
                cell_we = 1'b1;
                cell_wd = '{pop: r_cell_q.pop, dirty: 1'b1, head: r_cell_q.head};
            end
            S_LEMIT: begin
                part_addr = r_cur;
            end
            S_P0, S_LRD, S_LHEAD, S_LSTEP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            r_cell_mem[cell_addr] <= cell_wd;
        end
        r_cell_q <= r_cell_mem[cell_addr];
        if (part_we) begin
            r_part_mem[part_addr] <= part_wd;
        end
        r_part_q <= r_part_mem[part_addr];
    end

    function automatic t_result mk_res(logic [1:0] st, logic [11:0] cidx,
                                       logic [PCW-1:0] cnt, logic dirty,
                                       logic [11:0] mem, logic last);
        t_result res;
        res.status      = st;
        res.cell_index  = cidx;
        res.cell_count  = 13'(cnt);
        res.cell_active = cnt != '0;
        res.cell_dirty  = dirty;
        res.member      = mem;
        res.last        = last;
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_res_valid <= 1'b0;
            r_cols      <= RST_GRID_COLS;
            r_rows      <= RST_GRID_ROWS;
            r_plimit    <= RST_PARTICLE_LIMIT;
        end else begin
            r_res_valid <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_GRID_COLS:      r_cols   <= i_cfg_data[6:0];
                    REG_GRID_ROWS:      r_rows   <= i_cfg_data[6:0];
                    REG_PARTICLE_LIMIT: r_plimit <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == CLR_N - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_mode <= i_item.mode;
                        r_p    <= PW'(i_item.particle);
                        r_c    <= CW'(i_item.cell_select);
                        if (i_item.mode == MODE_LIST) begin
                            if (32'(i_item.cell_select) >= 32'(NCELLS)) begin
                                r_res_valid <= 1'b1;
                                r_res <= mk_res(ST_IGNORED, i_item.cell_select, '0, 1'b0,
                                                12'd0, 1'b1);
                            end else begin
                                r_state <= S_LHEAD;
                            end
                        end else if (ignored) begin
                            r_res_valid <= 1'b1;
                            r_res <= mk_res(ST_IGNORED, 12'd0, '0, 1'b0, 12'd0, 1'b1);
                        end else begin
                            r_state <= S_P0;
                        end
                    end
                end
                S_P0: begin
                    r_prec  <= r_part_q;
                    r_state <= S_P1;
                end
                S_P1: begin
                    r_c <= bin_cell;
                    if (r_mode == MODE_REMOVE) begin
                        if (!r_prec.valid) begin
                            r_res_valid <= 1'b1;
                            r_res <= mk_res(ST_UNBINNED, 12'd0, '0, 1'b0, 12'd0, 1'b1);
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_UCELL;
                        end
                    end else if (same_cell) begin
                        r_state <= S_DIRTY;
                    end else if (r_prec.valid) begin
                        r_state <= S_UCELL;
                    end else begin
                        r_state <= S_LINK;
                    end
                end
                S_UCELL: begin
                    r_crec.pop   <= r_cell_q.pop - 1'b1;
                    r_crec.dirty <= r_cell_q.dirty;
                    r_prev       <= r_cell_q.head;
                    if (r_cell_q.head == r_p) begin
                        r_crec.head <= r_prec.next;
                        r_state     <= S_UFIN;
                    end else begin
                        r_crec.head <= r_cell_q.head;
                        r_state     <= S_UWALK;
                    end
                end
                S_UWALK: begin
                    // One link per cycle until the predecessor of the particle is found.
                    if (r_part_q.next == r_p) begin
                        r_state <= S_UFIN;
                    end else begin
                        r_prev <= r_part_q.next;
                    end
                end
                S_UFIN: begin
                    if (r_mode == MODE_REMOVE) begin
                        r_res_valid <= 1'b1;
                        r_res <= mk_res(ST_OK, 12'(r_prec.home), r_crec.pop, r_crec.dirty,
                                        12'd0, 1'b1);
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_LRD;
                    end
                end
                S_LRD: begin
                    r_state <= S_LINK;
                end
                S_LINK: begin
                    r_res_valid <= 1'b1;
                    r_res <= mk_res(ST_OK, 12'(r_c), r_cell_q.pop + 1'b1, 1'b1, 12'd0, 1'b1);
                    r_state <= S_IDLE;
                end
                S_DIRTY: begin
                    r_res_valid <= 1'b1;
                    r_res <= mk_res(ST_OK, 12'(r_c), r_cell_q.pop, 1'b1, 12'd0, 1'b1);
                    r_state <= S_IDLE;
                end
                S_LHEAD: begin
                    r_crec <= r_cell_q;
                    r_cur  <= r_cell_q.head;
                    r_lcnt <= '0;
                    r_ln   <= (32'(r_cell_q.pop) > LIST_CAP) ? LCW'(LIST_CAP)
                                                             : LCW'(r_cell_q.pop);
                    if (r_cell_q.pop == '0) begin
                        r_res_valid <= 1'b1;
                        r_res <= mk_res(ST_EMPTY, 12'(r_c), '0, r_cell_q.dirty, 12'd0, 1'b1);
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_LEMIT;
                    end
                end
                S_LEMIT: begin
                    r_res_valid <= 1'b1;
                    r_res <= mk_res(ST_OK, 12'(r_c), r_crec.pop, r_crec.dirty, 12'(r_cur),
                                    (r_lcnt + 1'b1) == r_ln);
                    r_lcnt <= r_lcnt + 1'b1;
                    r_state <= ((r_lcnt + 1'b1) == r_ln) ? S_IDLE : S_LSTEP;
                end
                S_LSTEP: begin
                    r_cur   <= r_part_q.next;
                    r_state <= S_LEMIT;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = r_state != S_IDLE;
    assign o_res_valid = r_res_valid;
    assign o_result    = r_res;
    assign o_cfg_ready = 1'b1;

    // An error status always ends the transaction.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && (r_res.status != ST_OK) |-> r_res.last)
        else $error("error status without last");

    // A non-final result only comes from the member listing.
    a_more_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !r_res.last |-> r_state == S_LSTEP)
        else $error("non-final result outside list mode");

    a_list_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LEMIT |-> (r_lcnt < r_ln) && (32'(r_ln) <= LIST_CAP))
        else $error("list walk beyond its cap");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |=> !r_res_valid)
        else $error("result during clearing pass");

endmodule

[design/ugcl_bin.sv]
// Position to cell index unit: clamped column and row, then row * cols + col.
module ugcl_bin #(
    parameter int MAX_COLS   = ugcl_pkg::UGCL_MAX_COLS,
    parameter int MAX_ROWS   = ugcl_pkg::UGCL_MAX_ROWS,
    parameter int CELL_SHIFT = ugcl_pkg::UGCL_CELL_SHIFT
) (
    input  logic                                      i_clk,
    input  logic                                      i_load,
    input  logic signed [23:0]                        i_pos_x,
    input  logic signed [23:0]                        i_pos_y,
    input  logic [$clog2(MAX_COLS+1)-1:0]             i_cols,
    input  logic [$clog2(MAX_ROWS+1)-1:0]             i_rows,
    output logic [((MAX_COLS*MAX_ROWS) > 1 ? $clog2(MAX_COLS*MAX_ROWS) : 1)-1:0] o_cell
);
    import ugcl_pkg::*;

    localparam int SH   = 8 + CELL_SHIFT;
    localparam int CXW  = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
    localparam int CYW  = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
    localparam int CW   = (MAX_COLS*MAX_ROWS) > 1 ? $clog2(MAX_COLS*MAX_ROWS) : 1;

    logic [22:0]    sx, sy;
    logic [CXW-1:0] n_cx, r_cx;
    logic [CYW-1:0] n_cy, r_cy;
    logic [CW-1:0]  r_cell;

    always_comb begin
        sx = i_pos_x[22:0] >> SH;
        sy = i_pos_y[22:0] >> SH;
        if (i_pos_x[23]) begin
            n_cx = '0;
        end else if (sx >= 23'(i_cols)) begin
            n_cx = CXW'(i_cols - 1'b1);
        end else begin
            n_cx = CXW'(sx);
        end
        if (i_pos_y[23]) begin
            n_cy = '0;
        end else if (sy >= 23'(i_rows)) begin
            n_cy = CYW'(i_rows - 1'b1);
        end else begin
            n_cy = CYW'(sy);
        end
    end

    // Stage 2: product; user keeps grid size fixed while an item runs; unchecked.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
        end
        r_cell <= CW'(32'(r_cy) * 32'(i_cols) + 32'(r_cx));
    end

    assign o_cell = r_cell;

endmodule
